// ----- src/owoq_pkg.sv -----
`timescale 1ns / 1ps
package owoq_pkg;

    // Fixed widths set by the field formats
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GW_W       = 13;
    localparam int CPM_W      = 16;
    localparam int RANGE_W    = 31;
    localparam int POS_W      = 32;
    localparam int MUL_A_W    = 35;   // p - range - origin, exact
    localparam int MUL_B_W    = 17;   // cells_per_meter or grid_width, zero-extended
    localparam int PROD_W     = 52;
    localparam int CRD_W      = 28;   // cell coordinate
    localparam int BASE_W     = 42;   // signed linear index of a row start
    localparam int WIN_W      = 9;    // window width, up to the largest clamp
    localparam int LIM_W      = 25;   // cell count limit, up to the largest map
    localparam int DIST_W     = 16;
    localparam int FRAC_SHIFT = 24;
    localparam logic [PROD_W:0] HALF_Q24 = (PROD_W + 1)'(1) << (FRAC_SHIFT - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH      = 3'd0,
        CFG_GRID_HEIGHT     = 3'd1,
        CFG_ORIGIN_X        = 3'd2,
        CFG_ORIGIN_Y        = 3'd3,
        CFG_CELLS_PER_METER = 3'd4,
        CFG_SEARCH_RANGE    = 3'd5
    } t_cfg_idx;

    // Request action codes
    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef struct packed {
        logic        [GW_W-1:0]    grid_width;
        logic        [GW_W-1:0]    grid_height;
        logic signed [POS_W-1:0]   origin_x;
        logic signed [POS_W-1:0]   origin_y;
        logic        [CPM_W-1:0]   cells_per_meter;
        logic        [RANGE_W-1:0] search_range;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        grid_width:      13'd256,
        grid_height:     13'd256,
        origin_x:        32'sd0,
        origin_y:        32'sd0,
        cells_per_meter: 16'd5120,
        search_range:    31'd32768
    };

    // Window handed from the geometry unit to the scanner
    typedef struct packed {
        logic signed [BASE_W-1:0] base;
        logic        [WIN_W-1:0]  w;
        logic                     clamped;
        logic        [LIM_W-1:0]  limit;
    } t_window;

    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] min_dist;
        logic              clamped;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GEOM,
        ST_SCAN,
        ST_POST
    } t_state;

    typedef enum logic [2:0] {
        G_IDLE,
        G_OFFX1,
        G_OFFX2,
        G_OFFY1,
        G_AREA,
        G_ROW,
        G_BASE,
        G_DONE
    } t_geom_state;

    // Q24 cell value to cell coordinate: subtract one half, truncate toward zero
    function automatic logic signed [CRD_W-1:0] to_cell(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0]            v;
        logic signed [PROD_W-FRAC_SHIFT:0] q;
        v = $signed({p[PROD_W-1], p}) - $signed(HALF_Q24);
        q = v[PROD_W:FRAC_SHIFT];
        if (v[PROD_W] && (v[FRAC_SHIFT-1:0] != '0)) begin
            q = q + 1'b1;
        end
        return q[CRD_W-1:0];
    endfunction

endpackage

// ----- src/owoq_req_if.sv -----
`timescale 1ns / 1ps
interface owoq_req_if;
    logic                valid;
    logic                ready;
    logic                action;
    logic        [15:0]  cell_index;
    logic signed [7:0]   cell_value;
    logic signed [31:0]  query_x;
    logic signed [31:0]  query_y;

    modport source (
        output valid, action, cell_index, cell_value, query_x, query_y,
        input  ready
    );
    modport sink (
        input  valid, action, cell_index, cell_value, query_x, query_y,
        output ready
    );
endinterface

// ----- src/owoq_rsp_if.sv -----
`timescale 1ns / 1ps
interface owoq_rsp_if;
    logic        valid;
    logic        ready;
    logic        obstacle_found;
    logic [15:0] min_distance_quarter;
    logic        window_clamped;

    modport source (
        output valid, obstacle_found, min_distance_quarter, window_clamped,
        input  ready
    );
    modport sink (
        input  valid, obstacle_found, min_distance_quarter, window_clamped,
        output ready
    );
endinterface

// ----- src/owoq_map_ram.sv -----
`timescale 1ns / 1ps
module owoq_map_ram #(
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic                     i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic                     o_rd_data
);
    logic r_mem [DEPTH];
    logic r_rd_data;

    // Write one cell
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read: the data appears in the cycle after i_rd_en
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- src/owoq_geom.sv -----
`timescale 1ns / 1ps
module owoq_geom #(
    parameter int GRID_CELLS = 65536,
    parameter int MAX_WINDOW = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [owoq_pkg::POS_W-1:0] i_query_x,
    input  logic signed [owoq_pkg::POS_W-1:0] i_query_y,
    input  owoq_pkg::t_cfg                    i_cfg,
    output logic                              o_done,
    output owoq_pkg::t_window                 o_win
);
    localparam int AW = owoq_pkg::MUL_A_W;
    localparam int BW = owoq_pkg::MUL_B_W;
    localparam int PW = owoq_pkg::PROD_W;
    localparam int CW = owoq_pkg::CRD_W;

    owoq_pkg::t_geom_state r_state, n_state;

    logic signed [owoq_pkg::POS_W-1:0]  r_qx, r_qy;
    logic signed [PW-1:0]               r_prod;
    logic signed [PW-1:0]               n_prod;
    logic signed [AW-1:0]               mul_a;
    logic signed [BW-1:0]               mul_b;
    logic signed [AW-1:0]               qx_e, qy_e, ox_e, oy_e, rng_e;
    logic signed [CW-1:0]               r_x1, r_x2, r_y1;
    logic signed [CW:0]                 wdiff;
    logic signed [owoq_pkg::BASE_W-1:0] r_base;
    logic        [owoq_pkg::WIN_W-1:0]  r_w;
    logic                               r_clamped;
    logic        [owoq_pkg::LIM_W-1:0]  r_limit;

    // Next step of the setup sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            owoq_pkg::G_IDLE:  if (i_start) n_state = owoq_pkg::G_OFFX1;
            owoq_pkg::G_OFFX1: n_state = owoq_pkg::G_OFFX2;
            owoq_pkg::G_OFFX2: n_state = owoq_pkg::G_OFFY1;
            owoq_pkg::G_OFFY1: n_state = owoq_pkg::G_AREA;
            owoq_pkg::G_AREA:  n_state = owoq_pkg::G_ROW;
            owoq_pkg::G_ROW:   n_state = owoq_pkg::G_BASE;
            owoq_pkg::G_BASE:  n_state = owoq_pkg::G_DONE;
            owoq_pkg::G_DONE:  n_state = owoq_pkg::G_IDLE;
            default:           n_state = owoq_pkg::G_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= owoq_pkg::G_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sign-extended operands of the offset sums
    assign qx_e  = {{(AW - owoq_pkg::POS_W){r_qx[owoq_pkg::POS_W-1]}}, r_qx};
    assign qy_e  = {{(AW - owoq_pkg::POS_W){r_qy[owoq_pkg::POS_W-1]}}, r_qy};
    assign ox_e  = {{(AW - owoq_pkg::POS_W){i_cfg.origin_x[owoq_pkg::POS_W-1]}}, i_cfg.origin_x};
    assign oy_e  = {{(AW - owoq_pkg::POS_W){i_cfg.origin_y[owoq_pkg::POS_W-1]}}, i_cfg.origin_y};
    assign rng_e = {{(AW - owoq_pkg::RANGE_W){1'b0}}, i_cfg.search_range};

    // Select the multiplier operands for each step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            owoq_pkg::G_OFFX1: begin
                mul_a = qx_e - rng_e - ox_e;
                mul_b = {1'b0, i_cfg.cells_per_meter};
            end
            owoq_pkg::G_OFFX2: begin
                mul_a = qx_e + rng_e - ox_e;
                mul_b = {1'b0, i_cfg.cells_per_meter};
            end
            owoq_pkg::G_OFFY1: begin
                mul_a = qy_e - rng_e - oy_e;
                mul_b = {1'b0, i_cfg.cells_per_meter};
            end
            owoq_pkg::G_AREA: begin
                mul_a = {{(AW - owoq_pkg::GW_W){1'b0}}, i_cfg.grid_width};
                mul_b = {{(BW - owoq_pkg::GW_W){1'b0}}, i_cfg.grid_height};
            end
            owoq_pkg::G_ROW: begin
                mul_a = {{(AW - CW){r_y1[CW-1]}}, r_y1};
                mul_b = {{(BW - owoq_pkg::GW_W){1'b0}}, i_cfg.grid_width};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;
    assign wdiff  = {r_x2[CW-1], r_x2} - {r_x1[CW-1], r_x1};

    // Register the product, then fold it into the window one step later
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_start && (r_state == owoq_pkg::G_IDLE)) begin
            r_qx <= i_query_x;
            r_qy <= i_query_y;
        end
        case (r_state)
            owoq_pkg::G_OFFX2: r_x1 <= owoq_pkg::to_cell(r_prod);
            owoq_pkg::G_OFFY1: r_x2 <= owoq_pkg::to_cell(r_prod);
            owoq_pkg::G_AREA: begin
                r_y1 <= owoq_pkg::to_cell(r_prod);
                if (wdiff > $signed((CW + 1)'(MAX_WINDOW))) begin
                    r_w       <= owoq_pkg::WIN_W'(MAX_WINDOW);
                    r_clamped <= 1'b1;
                end else if (wdiff[CW]) begin
                    r_w       <= '0;
                    r_clamped <= 1'b0;
                end else begin
                    r_w       <= wdiff[owoq_pkg::WIN_W-1:0];
                    r_clamped <= 1'b0;
                end
            end
            owoq_pkg::G_ROW: begin
                if (r_prod > $signed(PW'(GRID_CELLS))) begin
                    r_limit <= owoq_pkg::LIM_W'(GRID_CELLS);
                end else begin
                    r_limit <= r_prod[owoq_pkg::LIM_W-1:0];
                end
            end
            owoq_pkg::G_BASE: begin
                r_base <= r_prod[owoq_pkg::BASE_W-1:0]
                        + {{(owoq_pkg::BASE_W - CW){r_x1[CW-1]}}, r_x1};
            end
            default: ;
        endcase
    end

    // Window out once every step has landed
    always_comb begin
        o_done          = (r_state == owoq_pkg::G_DONE);
        o_win.base      = r_base;
        o_win.w         = r_w;
        o_win.clamped   = r_clamped;
        o_win.limit     = r_limit;
    end
endmodule

// ----- src/owoq_scan.sv -----
`timescale 1ns / 1ps
module owoq_scan #(
    parameter int GRID_CELLS = 65536,
    parameter int MAX_WINDOW = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  owoq_pkg::t_window               i_win,
    input  logic [owoq_pkg::GW_W-1:0]       i_grid_width,
    output logic                            o_rd_en,
    output logic [$clog2(GRID_CELLS)-1:0]   o_rd_addr,
    input  logic                            i_rd_data,
    output logic                            o_done,
    output owoq_pkg::t_result               o_res
);
    localparam int AW   = $clog2(GRID_CELLS);
    localparam int WW   = $clog2(MAX_WINDOW + 1);
    localparam int DW   = $clog2(2 * MAX_WINDOW * MAX_WINDOW + 1);
    localparam int SQW  = 2 * (WW + 2);
    localparam int SATW = (DW > owoq_pkg::DIST_W + 1) ? DW : owoq_pkg::DIST_W + 1;
    localparam int BW   = owoq_pkg::BASE_W;

    logic                 r_busy;
    logic [WW-1:0]        r_i, r_j, r_w;
    logic signed [BW-1:0] r_row, r_idx;
    logic                 r_rd_v;
    logic [DW-1:0]        r_d, n_d;
    logic                 r_found;
    logic [DW-1:0]        r_best;
    logic                 rows_left, in_rng, issue, row_end;
    logic signed [WW+1:0] di, dj;
    logic signed [SQW-1:0] sq_i, sq_j;
    logic [BW-1:0]        gw_e;
    logic [SATW-1:0]      best_e;

    assign gw_e      = {{(BW - owoq_pkg::GW_W){1'b0}}, i_grid_width};
    assign rows_left = (r_i < r_w);
    assign in_rng    = !r_idx[BW-1]
                     && ($unsigned(r_idx) < {{(BW - owoq_pkg::LIM_W){1'b0}}, i_win.limit});
    assign issue     = r_busy && rows_left && (r_j < r_w) && in_rng;
    assign row_end   = r_busy && rows_left && !issue;
    assign o_done    = r_busy && !rows_left && !r_rd_v;

    // Squared distance of the issued cell to the window center, times four
    assign di   = $signed({1'b0, r_i, 1'b0}) - $signed({2'b00, r_w});
    assign dj   = $signed({1'b0, r_j, 1'b0}) - $signed({2'b00, r_w});
    assign sq_i = di * di;
    assign sq_j = dj * dj;
    assign n_d  = DW'($unsigned(sq_i)) + DW'($unsigned(sq_j));

    // Walk the window: one cell read per cycle within a row, with a step to the next row at each row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= issue;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
        if (i_start) begin
            r_i     <= '0;
            r_j     <= '0;
            r_w     <= WW'(i_win.w);
            r_row   <= i_win.base;
            r_idx   <= i_win.base;
            r_found <= 1'b0;
            r_best  <= '0;
        end else begin
            if (issue) begin
                r_j   <= r_j + 1'b1;
                r_idx <= r_idx + 1'b1;
            end else if (row_end) begin
                r_i   <= r_i + 1'b1;
                r_j   <= '0;
                r_row <= r_row + gw_e;
                r_idx <= r_row + gw_e;
            end
            // Keep the least distance of an occupied cell
            if (r_rd_v && i_rd_data && (!r_found || (r_d < r_best))) begin
                r_found <= 1'b1;
                r_best  <= r_d;
            end
        end
    end

    assign o_rd_en   = issue;
    assign o_rd_addr = r_idx[AW-1:0];

    // Saturate the distance to the result width
    assign best_e = SATW'(r_best);
    always_comb begin
        o_res.found    = r_found;
        o_res.clamped  = i_win.clamped;
        if (!r_found) begin
            o_res.min_dist = '0;
        end else if (best_e > SATW'({owoq_pkg::DIST_W{1'b1}})) begin
            o_res.min_dist = {owoq_pkg::DIST_W{1'b1}};
        end else begin
            o_res.min_dist = best_e[owoq_pkg::DIST_W-1:0];
        end
    end

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_i <= r_w) && (r_j <= r_w)))
        else $error("scan counters ran past the window");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !r_busy)
        else $error("scanner still busy after done");

    a_read_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> $past(r_busy))
        else $error("read data returned without a scan in flight");
endmodule

// ----- src/occupancy_window_obstacle_query.sv -----
`timescale 1ns / 1ps
// Occupancy window obstacle query.
// Request channel i_req: action 0 writes one map cell (set when cell_value > 0),
// action 1 asks whether any occupied cell lies in the square window around
// (query_x, query_y). Only queries produce a response on o_rsp.
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is high,
// only while no request is in flight.
// Timing: a load is written into the map as it is accepted. A query runs the
// coordinate setup through one shared multiplier, then the window scan, where
// w is the window width in cells (at most MAX_WINDOW); the scan reads one map
// cell per cycle from the single map memory, steps to the next row at each row
// end and drains the final read last. Rows that leave the map end early.
// o_rsp.valid rises once the scan is done and the output register is free,
// and i_req.ready returns in the same cycle.
// Only one request is worked on at a time; a request is taken while an earlier
// response still waits on o_rsp.
// Reset: the map memory is cleared one cell per cycle over all GRID_CELLS cells,
// with i_req.ready low; configuration writes are taken during that time.
// Stall: a finished query holds in the block until o_rsp.ready frees the output
// register; no request is taken meanwhile.
module occupancy_window_obstacle_query #(
    parameter int GRID_CELLS = 65536,
    parameter int MAX_WINDOW = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [owoq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [owoq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    owoq_req_if.sink                             i_req,
    owoq_rsp_if.source                           o_rsp
);
    localparam int AW = $clog2(GRID_CELLS);
    localparam int IW = (AW > 16) ? AW : 16;

    owoq_pkg::t_state  r_state, n_state;
    owoq_pkg::t_cfg    r_cfg;
    owoq_pkg::t_window win;
    owoq_pkg::t_result scan_res;
    owoq_pkg::t_result r_out;

    logic          r_out_valid;
    logic [AW-1:0] r_clr;
    logic          req_accept, is_query, out_free;
    logic          ready, clr_we, geom_start, out_load;
    logic          geom_done, scan_done;
    logic [IW-1:0] idx_e;
    logic          idx_ok;
    logic          mem_we, mem_wd;
    logic [AW-1:0] mem_wa;
    logic          rd_en, rd_data;
    logic [AW-1:0] rd_addr;

    assign req_accept = i_req.valid && ready;
    assign is_query   = (owoq_pkg::t_action'(i_req.action) == owoq_pkg::ACT_QUERY);
    assign out_free   = !r_out_valid || o_rsp.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owoq_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (owoq_pkg::t_cfg_idx'(i_cfg_idx))
                owoq_pkg::CFG_GRID_WIDTH:      r_cfg.grid_width  <= i_cfg_data[owoq_pkg::GW_W-1:0];
                owoq_pkg::CFG_GRID_HEIGHT:     r_cfg.grid_height <= i_cfg_data[owoq_pkg::GW_W-1:0];
                owoq_pkg::CFG_ORIGIN_X:        r_cfg.origin_x    <= $signed(i_cfg_data);
                owoq_pkg::CFG_ORIGIN_Y:        r_cfg.origin_y    <= $signed(i_cfg_data);
                owoq_pkg::CFG_CELLS_PER_METER: begin
                    r_cfg.cells_per_meter <= i_cfg_data[owoq_pkg::CPM_W-1:0];
                end
                owoq_pkg::CFG_SEARCH_RANGE: begin
                    r_cfg.search_range <= i_cfg_data[owoq_pkg::RANGE_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            owoq_pkg::ST_CLEAR: if (r_clr == AW'(GRID_CELLS - 1)) n_state = owoq_pkg::ST_IDLE;
            owoq_pkg::ST_IDLE:  if (req_accept && is_query) n_state = owoq_pkg::ST_GEOM;
            owoq_pkg::ST_GEOM:  if (geom_done) n_state = owoq_pkg::ST_SCAN;
            owoq_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = out_free ? owoq_pkg::ST_IDLE : owoq_pkg::ST_POST;
                end
            end
            owoq_pkg::ST_POST:  if (out_free) n_state = owoq_pkg::ST_IDLE;
            default:            n_state = owoq_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        ready      = (r_state == owoq_pkg::ST_IDLE);
        clr_we     = (r_state == owoq_pkg::ST_CLEAR);
        geom_start = req_accept && is_query;
        out_load   = (((r_state == owoq_pkg::ST_SCAN) && scan_done)
                     || (r_state == owoq_pkg::ST_POST)) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= owoq_pkg::ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Map write port: clearing pass, else a load request inside the map
    assign idx_e  = IW'(i_req.cell_index);
    assign idx_ok = ({1'b0, idx_e} < (IW + 1)'(GRID_CELLS));
    always_comb begin
        if (clr_we) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = 1'b0;
        end else begin
            mem_we = req_accept && !is_query && idx_ok;
            mem_wa = idx_e[AW-1:0];
            mem_wd = (i_req.cell_value > 8'sd0);
        end
    end

    owoq_map_ram #(
        .DEPTH(GRID_CELLS)
    ) u_map (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_wr_addr(mem_wa),
        .i_wr_data(mem_wd),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    owoq_geom #(
        .GRID_CELLS(GRID_CELLS),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (geom_start),
        .i_query_x(i_req.query_x),
        .i_query_y(i_req.query_y),
        .i_cfg    (r_cfg),
        .o_done   (geom_done),
        .o_win    (win)
    );

    owoq_scan #(
        .GRID_CELLS(GRID_CELLS),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (geom_done),
        .i_win       (win),
        .i_grid_width(r_cfg.grid_width),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_done      (scan_done),
        .o_res       (scan_res)
    );

    // Output register: hold the response until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= scan_res;
        end
    end

    assign i_req.ready                = ready;
    assign o_rsp.valid                = r_out_valid;
    assign o_rsp.obstacle_found       = r_out.found;
    assign o_rsp.min_distance_quarter = r_out.min_dist;
    assign o_rsp.window_clamped       = r_out.clamped;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_rsp.ready))
        else $error("response overwritten before it was taken");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == owoq_pkg::ST_SCAN) |-> !mem_we)
        else $error("map written during a window scan");

    a_geom_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        geom_done |-> (r_state == owoq_pkg::ST_GEOM))
        else $error("window setup finished outside its state");
endmodule
